// ----- rtl/srt_pkg.sv -----
// Shared types, constants and helpers of the sonar echo range timer.
// No dependencies; every other file of the block but srt_req_if refers to it by scoped names.
package srt_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned DistWidth  = 10;
   localparam int unsigned CsrIdxWidth = 4;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [DistWidth-1:0]  dist_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   // register map
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TRIGGER_COMPARE = 4'd0,
      CSR_MIN_VALID_TICKS = 4'd1
   } csr_addr_type;

   // item kinds
   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   localparam count_type COUNTER_TOP         = 16'hFFFF;
   localparam count_type TRIGGER_COMPARE_RST = 16'd65510;
   localparam count_type MIN_VALID_TICKS_RST = 16'd354;

   // width / 118 == (width >> 1) / 59; 59 done as multiply by ceil(2^21 / 59)
   localparam int unsigned RecipShift = 21;
   localparam logic [15:0] Recip59    = 16'd35545;

   function automatic dist_type ticks_to_cm(input count_type ticks);
      logic [14:0] half;
      logic [30:0] prod;
      begin
         half = ticks[15:1];
         prod = {16'd0, half} * {15'd0, Recip59};
         ticks_to_cm = prod[RecipShift +: DistWidth];
      end
   endfunction

endpackage

// ----- rtl/srt_req_if.sv -----
// Input channel of the sonar echo range timer: tick or read items.
// Has no dependencies.
interface srt_req_if;
   logic           valid;
   logic           ready;
   logic           mode;
   logic           echo_level;

   modport source (output valid, mode, echo_level, input ready);
   modport sink   (input valid, mode, echo_level, output ready);
endinterface

// ----- rtl/srt_rsp_if.sv -----
// Result channel of the sonar echo range timer.
// Depends on srt_pkg for the distance type.
interface srt_rsp_if;
   logic              valid;
   logic              ready;
   logic              trigger_level;
   srt_pkg::dist_type distance_cm;

   modport source (output valid, trigger_level, distance_cm, input ready);
   modport sink   (input valid, trigger_level, distance_cm, output ready);
endinterface

// ----- rtl/srt_csr_if.sv -----
// Register write channel of the sonar echo range timer.
// Depends on srt_pkg for the index and data types.
interface srt_csr_if;
   logic                 valid;
   logic                 ready;
   srt_pkg::csr_idx_type index;
   srt_pkg::count_type   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sonar_echo_range_timer_top.sv -----
// Top level of the sonar echo range timer: counter, echo edge capture,
// glitch filter and centimetre conversion. Depends on srt_pkg and the
// srt_req_if, srt_rsp_if and srt_csr_if interfaces.
//
// Usage:
//  - req_if carries one item per handshake: mode 0 is a timer tick with the
//    sampled echo pin level, mode 1 asks for the current distance.
//  - rsp_if returns exactly one item per request item: the trigger pin level
//    after that item and, for a read, the filtered echo width in cm (else 0).
//  - csr_if writes trigger_compare (index 0) or min_valid_ticks (index 1);
//    other indexes are dropped. Always ready; write only while idle.
//  - An item accepted at a clock edge shows on rsp_if right after that edge.
//    Throughput is one item per cycle while rsp_if is ready, set by the
//    single result register; the state update and the multiply-by-reciprocal
//    divide sit between the request handshake and that register.
//  - When the receiver stalls, the result register holds its item and
//    req_if.ready stays high only if that item leaves in the same cycle.
//  - Synchronous reset clears counter, widths, flags and the result valid,
//    and restores both registers to their defaults.
module sonar_echo_range_timer_top (
   input logic       clock,
   input logic       reset,
   srt_req_if.sink   req_if,
   srt_rsp_if.source rsp_if,
   srt_csr_if.sink   csr_if
);

   // configuration
   srt_pkg::count_type trig_cmp_ff, trig_cmp_in;
   srt_pkg::count_type min_ticks_ff, min_ticks_in;

   // timing state
   srt_pkg::count_type counter_ff, counter_in;
   srt_pkg::count_type start_ff, start_in;
   srt_pkg::count_type width_ff, width_in;
   srt_pkg::count_type prev_ff, prev_in;
   logic               finished_ff, finished_in;
   logic               trigger_ff, trigger_in;
   logic               last_echo_ff, last_echo_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_trig_ff, rsp_trig_in;
   srt_pkg::dist_type  rsp_dist_ff, rsp_dist_in;

   logic               req_take;
   logic               is_read;
   logic               rise, fall, at_cmp, at_wrap, glitch;
   srt_pkg::count_type width_edge, width_read;
   logic               fin_edge, trig_cmp;

   // result slot frees up when empty or being drained this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign is_read      = (req_if.mode == srt_pkg::MODE_READ);
   assign csr_if.ready = 1'b1;

   // tick path: edge first, then compare, then wrap
   assign rise       = req_if.echo_level && !last_echo_ff;
   assign fall       = !req_if.echo_level && last_echo_ff;
   assign width_edge = fall ? (counter_ff - start_ff) : width_ff;
   assign fin_edge   = fall || finished_ff;
   assign at_cmp     = (counter_ff == trig_cmp_ff);
   assign at_wrap    = (counter_ff == srt_pkg::COUNTER_TOP);
   assign trig_cmp   = at_cmp || trigger_ff;

   // read path: short widths fall back to the last good one
   assign glitch     = (width_ff < min_ticks_ff) && (prev_ff != '0);
   assign width_read = glitch ? prev_ff : width_ff;

   always_comb begin
      trig_cmp_in  = trig_cmp_ff;
      min_ticks_in = min_ticks_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            srt_pkg::CSR_TRIGGER_COMPARE: trig_cmp_in  = csr_if.data;
            srt_pkg::CSR_MIN_VALID_TICKS: min_ticks_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      counter_in   = counter_ff;
      start_in     = start_ff;
      width_in     = width_ff;
      prev_in      = prev_ff;
      finished_in  = finished_ff;
      trigger_in   = trigger_ff;
      last_echo_in = last_echo_ff;
      rsp_trig_in  = rsp_trig_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         if (is_read) begin
            width_in    = width_read;
            prev_in     = width_read;
            rsp_dist_in = srt_pkg::ticks_to_cm(width_read);
         end else begin
            if (rise) begin
               start_in = counter_ff;
            end
            width_in     = (at_cmp && !fin_edge) ? '0 : width_edge;
            finished_in  = fin_edge && !at_wrap;
            trigger_in   = trig_cmp && !at_wrap;
            last_echo_in = req_if.echo_level;
            counter_in   = counter_ff + 16'd1;
            rsp_dist_in  = '0;
         end
         rsp_trig_in = is_read ? trigger_ff : (trig_cmp && !at_wrap);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_cmp_ff  <= srt_pkg::TRIGGER_COMPARE_RST;
         min_ticks_ff <= srt_pkg::MIN_VALID_TICKS_RST;
         counter_ff   <= '0;
         start_ff     <= '0;
         width_ff     <= '0;
         prev_ff      <= '0;
         finished_ff  <= 1'b0;
         trigger_ff   <= 1'b0;
         last_echo_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trig_cmp_ff  <= trig_cmp_in;
         min_ticks_ff <= min_ticks_in;
         counter_ff   <= counter_in;
         start_ff     <= start_in;
         width_ff     <= width_in;
         prev_ff      <= prev_in;
         finished_ff  <= finished_in;
         trigger_ff   <= trigger_in;
         last_echo_ff <= last_echo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rsp_trig_ff <= rsp_trig_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.trigger_level = rsp_trig_ff;
   assign rsp_if.distance_cm   = rsp_dist_ff;

endmodule

// ----- test/srt_range_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sonar echo range timer: tracks register writes, predicts
// one result per accepted item and compares it. Depends on srt_pkg and the
// srt_req_if, srt_rsp_if and srt_csr_if interfaces.
module srt_range_checker (
   input  logic        clock,
   input  logic        reset,
   srt_req_if          req_if,
   srt_rsp_if          rsp_if,
   srt_csr_if          csr_if,
   output int unsigned mismatches,
   output int unsigned results_checked,
   output int unsigned results_due
);

   typedef struct packed {
      logic              trigger_level;
      srt_pkg::dist_type distance_cm;
   } range_reading_type;

   localparam srt_pkg::count_type TicksPerCm = 16'd118;

   // registers
   srt_pkg::count_type trig_at;
   srt_pkg::count_type glitch_floor;

   // timer and echo state
   srt_pkg::count_type tick_count;
   srt_pkg::count_type rise_mark;
   srt_pkg::count_type width_held;
   srt_pkg::count_type width_kept;
   logic               pulse_done;
   logic               trig_high;
   logic               echo_last;

   range_reading_type readings_due[$];
   int unsigned       error_tally;
   int unsigned       checked_tally;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t srt check: %s got %0d want %0d", $time, what, got, want);
      error_tally++;
   endtask

   // one item through the timer: tick advances the counter, read filters width
   task automatic predict_reading(input srt_pkg::mode_type kind, input logic level,
                                  output range_reading_type r);
      srt_pkg::count_type c;
      srt_pkg::dist_type  cm;
      c  = tick_count;
      cm = '0;
      if (kind == srt_pkg::MODE_READ) begin
         if (width_held < glitch_floor && width_kept != 0)
            width_held = width_kept;
         else
            width_kept = width_held;
         cm = srt_pkg::dist_type'(width_held / TicksPerCm);
      end else begin
         if (level && !echo_last) begin
            rise_mark = c;
         end else if (!level && echo_last) begin
            width_held = c - rise_mark;
            pulse_done = 1'b1;
         end
         echo_last = level;
         if (c == trig_at) begin
            if (!pulse_done)
               width_held = '0;
            trig_high = 1'b1;
         end
         // wrap beats a compare at the top value
         if (c == srt_pkg::COUNTER_TOP) begin
            trig_high  = 1'b0;
            pulse_done = 1'b0;
         end
         tick_count = c + 1'b1;
      end
      r.trigger_level = trig_high;
      r.distance_cm   = cm;
   endtask

   always @(posedge clock) begin : watch
      range_reading_type want;
      if (reset) begin
         trig_at      = srt_pkg::TRIGGER_COMPARE_RST;
         glitch_floor = srt_pkg::MIN_VALID_TICKS_RST;
         tick_count   = '0;
         rise_mark    = '0;
         width_held   = '0;
         width_kept   = '0;
         pulse_done   = 1'b0;
         trig_high    = 1'b0;
         echo_last    = 1'b0;
         readings_due.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               srt_pkg::CSR_TRIGGER_COMPARE: trig_at = csr_if.data;
               srt_pkg::CSR_MIN_VALID_TICKS: glitch_floor = csr_if.data;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("result with nothing due", 1, 0);
            end else begin
               want = readings_due.pop_front();
               checked_tally++;
               if (rsp_if.trigger_level !== want.trigger_level)
                  report_mismatch("trigger_level", rsp_if.trigger_level,
                                  want.trigger_level);
               if (rsp_if.distance_cm !== want.distance_cm)
                  report_mismatch("distance_cm", rsp_if.distance_cm, want.distance_cm);
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_reading(srt_pkg::mode_type'(req_if.mode), req_if.echo_level, want);
            readings_due.push_back(want);
         end
      end
      mismatches      <= error_tally;
      results_checked <= checked_tally;
      results_due     <= readings_due.size();
   end

endmodule

// ----- test/sonar_echo_range_timer_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the sonar echo range timer: clock, reset, stimulus and
// verdict. Depends on srt_pkg, the three channel interfaces, the block itself
// and srt_range_checker, which does all prediction and comparison.
module sonar_echo_range_timer_top_test;

   localparam int unsigned          LatencyPad      = 2;
   localparam int unsigned          HoldOffCycles   = 64;
   localparam int unsigned          DrainGuard      = 20000;
   localparam int unsigned          PhaseSteps      = 170; // five phases, at least 850 in all
   localparam srt_pkg::csr_idx_type CSR_SPARE_INDEX = 4'd9; // not in the register map

   logic clock;
   logic reset;

   srt_req_if req_chan();
   srt_rsp_if rsp_chan();
   srt_csr_if csr_chan();

   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned results_due;

   // stimulus bookkeeping; ticks_sent mirrors the block's free-running counter
   srt_pkg::count_type ticks_sent;
   int unsigned        items_sent;
   int unsigned        reads_sent;
   bit                 idle_on;
   bit                 hold_off_due;

   sonar_echo_range_timer_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan),
      .csr_if (csr_chan)
   );

   srt_range_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_chan),
      .rsp_if          (rsp_chan),
      .csr_if          (csr_chan),
      .mismatches      (mismatches),
      .results_checked (results_checked),
      .results_due     (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("sonar_echo_range_timer_top_test: errors");
      $finish;
   end

   // Result side: random stall bursts while idling is on, plus one long
   // hold-off on request so the single result register fills and the
   // block pushes back on the request side.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Offer one item and wait for the handshake. Valid stays high afterwards
   // so back-to-back items need no second assignment in the same step.
   task automatic send_item(input srt_pkg::mode_type kind, input logic level);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= kind;
      req_chan.echo_level <= level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (kind == srt_pkg::MODE_READ)
         reads_sent++;
      else
         ticks_sent++;
   endtask

   // Stop offering and wait for every predicted result to come back.
   // It waits on the clock first: the checker's count is registered and lags the acceptance edge.
   task automatic drain_results();
      int unsigned guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0 && guard < DrainGuard) begin
         @(posedge clock);
         guard++;
      end
      repeat (LatencyPad) @(posedge clock);
   endtask

   task automatic write_csr(input srt_pkg::csr_idx_type idx, input srt_pkg::count_type value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   // both registers, then a write to an unmapped index that must be dropped
   task automatic set_registers(input srt_pkg::count_type trig_value,
                                input srt_pkg::count_type floor_ticks);
      write_csr(srt_pkg::CSR_TRIGGER_COMPARE, trig_value);
      write_csr(srt_pkg::CSR_MIN_VALID_TICKS, floor_ticks);
      write_csr(CSR_SPARE_INDEX, srt_pkg::count_type'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   // Mostly complete echo pulses (low, high for a while, fall, then reads),
   // with some noise, reads in the middle of a pulse, bare reads and drains. Every
   // item counts as a step, so a long pulse takes a large share of a phase.
   task automatic run_echo_sequences(input int unsigned steps);
      int unsigned done_steps;
      int unsigned pick;
      int unsigned n;
      int unsigned hold;
      done_steps = 0;
      while (done_steps < steps) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(srt_pkg::MODE_TICK, 1'b0);
            done_steps += n;
            pick = $urandom_range(0, 9);
            if (pick < 6)
               hold = $urandom_range(1, 40);
            else if (pick < 9)
               hold = $urandom_range(118, 240);
            else
               hold = $urandom_range(240, 480);
            repeat (hold) send_item(srt_pkg::MODE_TICK, 1'b1);
            send_item(srt_pkg::MODE_TICK, 1'b0);
            n = $urandom_range(1, 3);
            repeat (n) send_item(srt_pkg::MODE_READ, 1'($urandom_range(0, 1)));
            done_steps += hold + n + 1;
         end else if (pick < 16) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(srt_pkg::mode_type'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            done_steps += n;
         end else if (pick < 18) begin
            // read while the echo is still high; the fall may never come
            hold = $urandom_range(1, 20);
            repeat (hold) send_item(srt_pkg::MODE_TICK, 1'b1);
            n = $urandom_range(1, 2);
            repeat (n) send_item(srt_pkg::MODE_READ, 1'($urandom_range(0, 1)));
            done_steps += hold + n;
            if ($urandom_range(0, 1) == 0) begin
               send_item(srt_pkg::MODE_TICK, 1'b0);
               done_steps++;
            end
         end else if (pick == 18) begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(srt_pkg::MODE_READ, 1'($urandom_range(0, 1)));
            done_steps += n;
         end else begin
            drain_results();
         end
      end
   endtask

   initial begin : stimulus
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= srt_pkg::MODE_TICK;
      req_chan.echo_level <= 1'b0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= srt_pkg::CSR_TRIGGER_COMPARE;
      csr_chan.data       <= '0;
      ticks_sent   = '0;
      items_sent   = 0;
      reads_sent   = 0;
      idle_on      = 1'b0;
      hold_off_due = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset register values. First read: no width and no
      // previous width, so zero is taken. Short pulse then read: below the
      // glitch floor but nothing saved yet, so it is kept. Shorter pulse:
      // now a glitch, the saved width is returned instead.
      send_item(srt_pkg::MODE_READ, 1'b0);
      send_item(srt_pkg::MODE_TICK, 1'b0);
      repeat (4) send_item(srt_pkg::MODE_TICK, 1'b1);
      send_item(srt_pkg::MODE_TICK, 1'b0);
      send_item(srt_pkg::MODE_READ, 1'b0);
      send_item(srt_pkg::MODE_READ, 1'b1);       // echo level ignored on a read
      send_item(srt_pkg::MODE_TICK, 1'b1);
      send_item(srt_pkg::MODE_TICK, 1'b0);
      send_item(srt_pkg::MODE_READ, 1'b0);
      send_item(srt_pkg::MODE_TICK, 1'b1);       // rise, then read mid-pulse
      send_item(srt_pkg::MODE_READ, 1'b0);
      send_item(srt_pkg::MODE_READ, 1'b0);       // counter must not move on reads
      send_item(srt_pkg::MODE_TICK, 1'b1);
      send_item(srt_pkg::MODE_TICK, 1'b0);
      send_item(srt_pkg::MODE_READ, 1'b1);
      send_item(srt_pkg::MODE_TICK, 1'b0);
      drain_results();

      // Random phases. Compare values just ahead of the counter raise the
      // trigger part way through; only a wrap lowers it again.
      idle_on = 1'b1;
      set_registers(srt_pkg::count_type'(ticks_sent + 16'd30), 16'd0);
      run_echo_sequences(PhaseSteps);

      drain_results();
      set_registers(srt_pkg::count_type'(ticks_sent + 16'd150), 16'hFFFF);
      hold_off_due = 1'b1;              // receiver stalls while items keep coming
      run_echo_sequences(PhaseSteps);

      drain_results();
      set_registers(srt_pkg::count_type'($urandom),
                    srt_pkg::count_type'($urandom_range(0, 300)));
      run_echo_sequences(PhaseSteps);

      drain_results();
      set_registers(srt_pkg::count_type'(ticks_sent + 16'd20),
                    srt_pkg::count_type'($urandom_range(1, 200)));
      run_echo_sequences(PhaseSteps);

      // final phase runs with no idling on either side
      drain_results();
      idle_on = 1'b0;
      set_registers(srt_pkg::count_type'(ticks_sent + 16'd5),
                    srt_pkg::count_type'($urandom_range(0, 600)));
      run_echo_sequences(PhaseSteps);

      drain_results();
      $display("run: %0d items (%0d reads), %0d results checked",
               items_sent, reads_sent, results_checked);
      $display("run: directed glitch cases, compare ahead of the counter, floor at 0 and 65535");
      if (mismatches == 0 && results_due == 0)
         $display("sonar_echo_range_timer_top_test: clean");
      else
         $display("sonar_echo_range_timer_top_test: errors");
      $finish;
   end

endmodule
